// ----- sv/weighted_chi_square_accumulator_assert.svh -----
// Assertion macros for the weighted chi-square accumulator port checker.
`ifndef WEIGHTED_CHI_SQUARE_ACCUMULATOR_ASSERT_SVH
`define WEIGHTED_CHI_SQUARE_ACCUMULATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WCSA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WCSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/wcsa_pkg.sv -----
// Types and constants shared by the weighted chi-square accumulator modules.
`default_nettype none

package wcsa_pkg;

    // Field widths of the input and result beats.
    localparam int VALUE_W   = 32;
    localparam int ERROR_W   = 31;
    localparam int SUM_W     = 56;

    // Configuration port.
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 1;
    localparam int MIN_DEN_W   = 32;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_ERROR_MODE = 1'd0;
    localparam cfg_index_t REG_MIN_DENOM  = 1'd1;

    // Serial squarer: one lane per operand, all lanes 32 bits wide.
    localparam int MUL_W     = 32;
    localparam int MUL_LANES = 3;
    localparam int LANE_DIFF = 0;
    localparam int LANE_MERR = 1;
    localparam int LANE_DERR = 2;

    // Squared difference and denominator widths.
    localparam int SQ_W  = 64;
    localparam int DEN_W = 63;

    typedef logic [SUM_W-1:0] sum_t;

    localparam sum_t SUM_MAX = {SUM_W{1'b1}};

endpackage

`default_nettype wire

// ----- sv/wcsa_sqmul.sv -----
// Bit-serial shift-add squarer with three lanes sharing one bit counter.
`default_nettype none

module wcsa_sqmul
    import wcsa_pkg::*;
#(
    parameter int W = 32
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic [MUL_LANES-1:0][W-1:0]       opnd,
    output logic      [MUL_LANES-1:0][2*W-1:0]     sq,
    output logic                                   done
);

    localparam int CNT_W = (W > 1) ? $clog2(W) : 1;

    logic             busy_reg;
    logic             busy_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    logic [W-1:0]     a_reg [MUL_LANES];
    logic [2*W-1:0]   p_reg [MUL_LANES];

    // The last multiplier bit is consumed in the final busy cycle.
    assign done = busy_reg && (cnt_reg == CNT_W'(W - 1));

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (done)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Each lane adds the multiplicand into the upper half when the low bit is set,
    // then shifts the product right by one bit.
    for (genvar l = 0; l < MUL_LANES; l++)
    begin : g_lane
        logic [W:0]     psum;
        logic [2*W-1:0] p_next;

        assign psum   = {1'b0, p_reg[l][2*W-1:W]}
                        + (p_reg[l][0] ? {1'b0, a_reg[l]} : {(W+1){1'b0}});
        assign p_next = {psum, p_reg[l][W-1:1]};

        always_ff @(posedge clk)
        begin
            if (start)
            begin
                a_reg[l] <= opnd[l];
                p_reg[l] <= {{W{1'b0}}, opnd[l]};
            end
            else if (busy_reg)
            begin
                p_reg[l] <= p_next;
            end
        end

        assign sq[l] = p_reg[l];
    end

endmodule

`default_nettype wire

// ----- sv/wcsa_serdiv.sv -----
// Bit-serial restoring divider with an overflow flag for quotients past the output width.
`default_nettype none

module wcsa_serdiv
    import wcsa_pkg::*;
#(
    parameter int NUM_W = 80,
    parameter int D_W   = 63,
    parameter int Q_W   = 56
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [D_W-1:0]   den,
    output logic      [Q_W-1:0]   quot,
    output logic                  big,
    output logic                  done
);

    localparam int CNT_W     = $clog2(NUM_W);
    localparam int HIGH_BITS = NUM_W - Q_W;

    logic             busy_reg;
    logic             busy_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    logic [NUM_W-1:0] num_reg;
    logic [D_W-1:0]   den_reg;
    logic [D_W-1:0]   rem_reg;
    logic [D_W-1:0]   rem_next;
    logic [Q_W-1:0]   quot_reg;
    logic             big_reg;

    logic [D_W:0]     trial;
    logic [D_W:0]     trial_sub;
    logic             ge;
    logic             high_phase;

    assign done = busy_reg && (cnt_reg == CNT_W'(NUM_W - 1));

    // One quotient bit per cycle: bring down the next dividend bit and try the subtract.
    always_comb
    begin
        trial      = {rem_reg, num_reg[NUM_W-1]};
        trial_sub  = trial - {1'b0, den_reg};
        ge         = (trial >= {1'b0, den_reg});
        rem_next   = ge ? trial_sub[D_W-1:0] : trial[D_W-1:0];
        high_phase = (cnt_reg < CNT_W'(HIGH_BITS));
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (done)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers; a quotient bit above the output width only raises the flag.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg  <= num;
            den_reg  <= den;
            rem_reg  <= '0;
            quot_reg <= '0;
            big_reg  <= 1'b0;
        end
        else if (busy_reg)
        begin
            num_reg  <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[Q_W-2:0], ge};
            big_reg  <= big_reg | (ge & high_phase);
        end
    end

    assign quot = quot_reg;
    assign big  = big_reg;

endmodule

`default_nettype wire

// ----- sv/weighted_chi_square_accumulator.sv -----
// Top level of the weighted chi-square accumulator: control, accumulation and result register.
//
//  Channel  | Signals                                         | Direction
//  ---------+-------------------------------------------------+----------
//  in       | in_valid, in_stall, model_value, data_value,    | to block
//           | model_error, data_error, last_item              |
//  out      | out_valid, out_stall, chi_square, overflowed    | from block
//  cfg      | cfg_we, cfg_index, cfg_data                     | to block
//
// A bin passes through the accept cycle in S_IDLE, the serial squarer, the threshold
// check, the serial divider and the accumulate step; a skipped bin leaves after the
// threshold check. A last beat then loads the result register in S_EMIT, which waits
// while that register is still stalled downstream.
// Reset returns the configuration to its defaults and clears the sum; nothing else
// needs clearing. A waiting result does not block the next bin unless it is also last.
`default_nettype none

module weighted_chi_square_accumulator
    import wcsa_pkg::*;
#(
    parameter int FRACTION_BITS = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [VALUE_W-1:0]     model_value,
    input  wire logic [VALUE_W-1:0]     data_value,
    input  wire logic [ERROR_W-1:0]     model_error,
    input  wire logic [ERROR_W-1:0]     data_error,
    input  wire logic                   last_item,

    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic      [SUM_W-1:0]       chi_square,
    output logic                        overflowed,

    input  wire logic                   cfg_we,
    input  wire cfg_index_t             cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int NUM_W = SQ_W + FRACTION_BITS;

    // Control states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_ACC   = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0]           state_reg;
    logic [2:0]           state_next;
    logic                 last_reg;
    logic                 last_next;
    sum_t                 sum_reg;
    sum_t                 sum_next;
    logic                 sat_reg;
    logic                 sat_next;

    logic                 error_mode_reg;
    logic [MIN_DEN_W-1:0] min_den_reg;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    sum_t                 chi_reg;
    logic                 ovf_reg;

    logic                 in_fire;
    logic                 out_free;
    logic                 load_out;
    logic                 div_start;

    logic [VALUE_W:0]     diff;
    logic [VALUE_W:0]     diff_neg;
    logic [MUL_W-1:0]     diff_mag;

    logic [MUL_LANES-1:0][MUL_W-1:0]   mul_opnd;
    logic [MUL_LANES-1:0][2*MUL_W-1:0] mul_sq;
    logic                 mul_done;

    logic [DEN_W-1:0]     me_sq;
    logic [DEN_W-1:0]     de_sq;
    logic [DEN_W-1:0]     den;
    logic                 den_ok;

    logic [NUM_W-1:0]     div_num;
    logic [SUM_W-1:0]     div_quot;
    logic                 div_big;
    logic                 div_done;

    logic [SUM_W:0]       sum_ext;
    logic                 acc_sat;

    assign in_stall = (state_reg != S_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Magnitude of the value difference; it always fits in 32 bits.
    always_comb
    begin
        diff     = {model_value[VALUE_W-1], model_value} - {data_value[VALUE_W-1], data_value};
        diff_neg = ~diff + {{VALUE_W{1'b0}}, 1'b1};
        diff_mag = diff[VALUE_W] ? diff_neg[MUL_W-1:0] : diff[MUL_W-1:0];
    end

    // Squarer lanes start on the accepted beat.
    always_comb
    begin
        mul_opnd            = '0;
        mul_opnd[LANE_DIFF] = diff_mag;
        mul_opnd[LANE_MERR] = {1'b0, model_error};
        mul_opnd[LANE_DERR] = {1'b0, data_error};
    end

    wcsa_sqmul #(
        .W     (MUL_W)
    ) u_sqmul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_fire),
        .opnd  (mul_opnd),
        .sq    (mul_sq),
        .done  (mul_done)
    );

    // Denominator and threshold test.
    always_comb
    begin
        me_sq  = mul_sq[LANE_MERR][DEN_W-1:0];
        de_sq  = mul_sq[LANE_DERR][DEN_W-1:0];
        den    = de_sq + (error_mode_reg ? {DEN_W{1'b0}} : me_sq);
        den_ok = (den != '0) && (den >= {{(DEN_W-MIN_DEN_W){1'b0}}, min_den_reg});
    end

    assign div_num = {mul_sq[LANE_DIFF], {FRACTION_BITS{1'b0}}};

    wcsa_serdiv #(
        .NUM_W (NUM_W),
        .D_W   (DEN_W),
        .Q_W   (SUM_W)
    ) u_serdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (den),
        .quot  (div_quot),
        .big   (div_big),
        .done  (div_done)
    );

    // Saturating accumulate of one quotient.
    always_comb
    begin
        sum_ext = {1'b0, sum_reg} + {1'b0, div_quot};
        acc_sat = div_big || sum_ext[SUM_W];
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        sum_next   = sum_reg;
        sat_next   = sat_reg;
        div_start  = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    last_next  = last_item;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (mul_done)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (den_ok)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = last_reg ? S_EMIT : S_IDLE;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                sum_next   = acc_sat ? SUM_MAX : sum_ext[SUM_W-1:0];
                sat_next   = sat_reg | acc_sat;
                state_next = last_reg ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    sum_next   = '0;
                    sat_next   = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            last_reg  <= 1'b0;
            sum_reg   <= '0;
            sat_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
            sum_reg   <= sum_next;
            sat_reg   <= sat_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_mode_reg <= 1'b0;
            min_den_reg    <= MIN_DEN_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ERROR_MODE: error_mode_reg <= cfg_data[0];
                REG_MIN_DENOM:  min_den_reg    <= cfg_data[MIN_DEN_W-1:0];
                default:        error_mode_reg <= error_mode_reg;
            endcase
        end
    end

    // Result register: holds a beat until downstream takes it.
    assign out_valid_next = load_out || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            chi_reg <= sum_reg;
            ovf_reg <= sat_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign chi_square = chi_reg;
    assign overflowed = ovf_reg;

endmodule

`default_nettype wire

// ----- sv/wcsa_checker.sv -----
// Port-level checker for the weighted chi-square accumulator, bound to the top level.
`default_nettype none

`include "weighted_chi_square_accumulator_assert.svh"

module wcsa_checker
    import wcsa_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             in_valid,
    input wire logic             in_stall,
    input wire logic             out_valid,
    input wire logic             out_stall,
    input wire logic [SUM_W-1:0] chi_square,
    input wire logic             overflowed
);

    // A stalled result beat stays offered.
    `WCSA_ASSERT_NEXT(a_out_valid_holds, out_valid && out_stall, out_valid, "out_valid dropped while stalled")

    // A stalled result beat keeps its payload.
    `WCSA_ASSERT_NEXT(a_out_payload_holds, out_valid && out_stall, $stable(chi_square) && $stable(overflowed), "result changed while stalled")

    // One bin at a time: the input stalls right after a beat is taken.
    `WCSA_ASSERT_NEXT(a_in_busy_after_accept, in_valid && !in_stall, in_stall, "input taken while a bin was in progress")

    // A saturated run reports full scale.
    `WCSA_ASSERT_SAME(a_overflow_full_scale, out_valid && overflowed, &chi_square, "overflow flagged without a saturated sum")

endmodule

bind weighted_chi_square_accumulator wcsa_checker u_wcsa_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .chi_square (chi_square),
    .overflowed (overflowed)
);

`default_nettype wire

// ----- sim/chi_square_checker.sv -----
// Checker for the weighted chi-square accumulator: predicts each sum and compares result beats.
`timescale 1ns / 100ps

module chi_square_checker
    import wcsa_pkg::*;
#(
    parameter int FRACTION_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic [VALUE_W-1:0]     model_value,
    input  logic [VALUE_W-1:0]     data_value,
    input  logic [ERROR_W-1:0]     model_error,
    input  logic [ERROR_W-1:0]     data_error,
    input  logic                   last_item,

    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic [SUM_W-1:0]       chi_square,
    input  logic                   overflowed,

    input  logic                   cfg_we,
    input  cfg_index_t             cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    output int                     mismatch_count,
    output int                     sums_outstanding
);

    typedef struct packed {
        sum_t chi;
        logic ovf;
    } chi_result_t;

    // Shadow copy of the configuration and of the running sum.
    logic                 error_mode_q;
    logic [MIN_DEN_W-1:0] min_denom_q;
    sum_t                 running_chi;
    logic                 running_sat;

    chi_result_t expected_sums[$];
    int          mismatch_total = 0;
    int          outstanding    = 0;

    assign mismatch_count   = mismatch_total;
    assign sums_outstanding = outstanding;

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t ns: %s", $time, msg);
        mismatch_total++;
    endtask

    // Adds one bin's contribution to the shadow sum, saturating at full scale.
    task automatic fold_bin(input logic [VALUE_W-1:0] mv, input logic [VALUE_W-1:0] dv,
                            input logic [ERROR_W-1:0] me, input logic [ERROR_W-1:0] de);
        logic signed [VALUE_W:0] diff;
        logic [VALUE_W-1:0]      mag;
        logic [63:0]             diff_sq;
        logic [63:0]             denom;
        logic [127:0]            quot;
        logic [SUM_W:0]          total;
        diff    = $signed({mv[VALUE_W-1], mv}) - $signed({dv[VALUE_W-1], dv});
        mag     = diff[VALUE_W] ? (~diff[VALUE_W-1:0] + 32'd1) : diff[VALUE_W-1:0];
        diff_sq = {32'd0, mag} * {32'd0, mag};
        denom   = {33'd0, de} * {33'd0, de};
        if (!error_mode_q)
        begin
            denom = denom + {33'd0, me} * {33'd0, me};
        end
        // A zero denominator is skipped even when the threshold is zero.
        if (denom != 64'd0 && denom >= {32'd0, min_denom_q})
        begin
            quot  = ({64'd0, diff_sq} << FRACTION_BITS) / {64'd0, denom};
            total = {1'b0, running_chi} + quot[SUM_W:0];
            if (quot > {72'd0, SUM_MAX} || total > {1'b0, SUM_MAX})
            begin
                running_chi = SUM_MAX;
                running_sat = 1'b1;
            end
            else
            begin
                running_chi = total[SUM_W-1:0];
            end
        end
    endtask

    // Compares a result beat with the oldest predicted sum.
    task automatic check_result();
        chi_result_t want;
        if (expected_sums.size() == 0)
        begin
            report_mismatch($sformatf("result beat with nothing expected: chi_square=%h",
                                      chi_square));
        end
        else
        begin
            want = expected_sums.pop_front();
            outstanding--;
            if (chi_square !== want.chi)
            begin
                report_mismatch($sformatf("chi_square %h, expected %h", chi_square, want.chi));
            end
            if (overflowed !== want.ovf)
            begin
                report_mismatch($sformatf("overflowed %b, expected %b", overflowed, want.ovf));
            end
        end
    endtask

    // Watches all three channels at each rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_mode_q = 1'b0;
            min_denom_q  = 32'd1;
            running_chi  = '0;
            running_sat  = 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                check_result();
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ERROR_MODE: error_mode_q = cfg_data[0];
                    REG_MIN_DENOM:  min_denom_q  = cfg_data[MIN_DEN_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                fold_bin(model_value, data_value, model_error, data_error);
                if (last_item)
                begin
                    expected_sums.push_back('{chi: running_chi, ovf: running_sat});
                    outstanding++;
                    running_chi = '0;
                    running_sat = 1'b0;
                end
            end
        end
    end

endmodule

// ----- sim/tb_weighted_chi_square_accumulator.sv -----
// Testbench top for the weighted chi-square accumulator: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_weighted_chi_square_accumulator;

    import wcsa_pkg::*;

    localparam int FRAC_BITS = 16;
    // Drain time after the last result: longer than one bin plus the result load.
    localparam int DRAIN_CYCLES = 140;

    logic                  clk = 1'b0;
    logic                  rst_n;

    logic                  in_valid;
    logic                  in_stall;
    logic [VALUE_W-1:0]    model_value;
    logic [VALUE_W-1:0]    data_value;
    logic [ERROR_W-1:0]    model_error;
    logic [ERROR_W-1:0]    data_error;
    logic                  last_item;

    logic                  out_valid;
    logic                  out_stall;
    logic [SUM_W-1:0]      chi_square;
    logic                  overflowed;

    logic                  cfg_we;
    cfg_index_t            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int                    mismatch_count;
    int                    sums_outstanding;
    logic                  sender_calm;

    weighted_chi_square_accumulator #(
        .FRACTION_BITS (FRAC_BITS)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .model_value (model_value),
        .data_value  (data_value),
        .model_error (model_error),
        .data_error  (data_error),
        .last_item   (last_item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .chi_square  (chi_square),
        .overflowed  (overflowed),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    chi_square_checker #(
        .FRACTION_BITS (FRAC_BITS)
    ) checker_inst (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .model_value      (model_value),
        .data_value       (data_value),
        .model_error      (model_error),
        .data_error       (data_error),
        .last_item        (last_item),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .chi_square       (chi_square),
        .overflowed       (overflowed),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mismatch_count   (mismatch_count),
        .sums_outstanding (sums_outstanding)
    );

    // 8 ns clock.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Hard limit on the run time.
    initial
    begin
        #8_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Result-side stall: short and long bursts, with calm stretches between.
    initial
    begin
        int hold;
        int calm;
        int roll;
        out_stall = 1'b0;
        hold = 0;
        calm = 0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                hold--;
            end
            else
            begin
                out_stall <= 1'b0;
                if (calm > 0)
                begin
                    calm--;
                end
                else
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 8)
                        hold = $urandom_range(1, 4);
                    else if (roll == 8)
                        hold = $urandom_range(20, 60);
                    else if (roll == 9)
                        calm = $urandom_range(50, 400);
                end
            end
        end
    end

    // Gap before a bin beat: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Bin content: extremes, full range, or moderate values of either sign.
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] v;
        case ($urandom_range(0, 7))
            0:       v = $urandom;
            1:       v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2, 3:    v = $urandom_range(0, 32'h00FF_FFFF);
            default: v = $urandom_range(0, 32'h0040_0000);
        endcase
        if ($urandom_range(0, 2) == 0)
            v = -v;
        return v;
    endfunction

    // Bin error: zero, full scale, full range, tiny or moderate.
    function automatic logic [ERROR_W-1:0] pick_error();
        logic [ERROR_W-1:0] e;
        case ($urandom_range(0, 9))
            0:       e = '0;
            1:       e = 31'h7FFF_FFFF;
            2:       e = 31'($urandom);
            3, 4:    e = 31'($urandom_range(1, 32'h0000_0400));
            default: e = 31'($urandom_range(32'h0000_0100, 32'h0008_0000));
        endcase
        return e;
    endfunction

    // Drives one bin beat and returns once it has been accepted.
    task automatic send_bin(input logic [VALUE_W-1:0] mv, input logic [VALUE_W-1:0] dv,
                            input logic [ERROR_W-1:0] me, input logic [ERROR_W-1:0] de,
                            input logic is_last);
        int gap;
        gap = sender_calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        model_value <= mv;
        data_value  <= dv;
        model_error <= me;
        data_error  <= de;
        last_item   <= is_last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Drops valid once the final beat of a run has gone.
    task automatic release_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Waits for every predicted sum, then lets the block settle.
    task automatic wait_idle();
        while (sums_outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Upper bits of the mode write are random; only bit 0 counts.
    task automatic set_config(input logic mode, input logic [MIN_DEN_W-1:0] min_den);
        write_reg(REG_ERROR_MODE, {31'($urandom), mode});
        write_reg(REG_MIN_DENOM, min_den);
    endtask

    // Random bins in runs of random length; the final bin always closes a run.
    task automatic random_bins(input int count);
        logic [VALUE_W-1:0] dv;
        logic [VALUE_W-1:0] mv;
        logic [VALUE_W-1:0] offset;
        sender_calm = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < count; i++)
        begin
            dv = pick_value();
            // Model and data are usually close, as in a real fit.
            if ($urandom_range(0, 1) == 0)
            begin
                offset = $urandom_range(0, 32'h0003_FFFF);
                mv = $urandom_range(0, 1) ? dv + offset : dv - offset;
            end
            else
            begin
                mv = pick_value();
            end
            send_bin(mv, dv, pick_error(), pick_error(),
                     (i == count - 1) || ($urandom_range(0, 7) == 0));
        end
        release_input();
        wait_idle();
    endtask

    // Stimulus.
    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        model_value = '0;
        data_value  = '0;
        model_error = '0;
        data_error  = '0;
        last_item   = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = REG_ERROR_MODE;
        cfg_data    = '0;
        sender_calm = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Configuration as it comes out of reset.
        random_bins($urandom_range(70, 100));

        // Directed bins, both errors counted, no threshold.
        set_config(1'b0, 32'd0);
        // Zero denominator on a last bin: skipped, still emits a zero sum.
        send_bin(32'd0, 32'd0, 31'd0, 31'd0, 1'b1);
        // Unit difference over unit error gives exactly one.
        send_bin(32'h0001_0000, 32'd0, 31'h0001_0000, 31'd0, 1'b1);
        // Largest difference over the smallest error saturates in one bin.
        send_bin(32'h7FFF_FFFF, 32'h8000_0000, 31'd1, 31'd0, 1'b0);
        send_bin(32'd1, 32'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1);
        // Largest negative difference over the largest denominator.
        send_bin(32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1);
        // Three bins just under half scale: the third one overflows the sum.
        send_bin(32'h000B_5000, 32'd0, 31'd1, 31'd0, 1'b0);
        send_bin(32'h000B_5000, 32'd0, 31'd1, 31'd0, 1'b0);
        send_bin(32'h000B_5000, 32'd0, 31'd1, 31'd0, 1'b1);
        // A skipped last bin still closes the run with the earlier sum.
        send_bin(32'h0003_0000, 32'h0001_0000, 31'h0000_8000, 31'h0000_8000, 1'b0);
        send_bin(32'd5, 32'd5, 31'd0, 31'd0, 1'b1);
        send_bin(32'hFFFF_FFFF, 32'h8000_0000, 31'h0000_0100, 31'h0000_0100, 1'b1);
        send_bin(32'h7FFF_FFFF, 32'd0, 31'd0, 31'h7FFF_FFFF, 1'b1);
        release_input();
        wait_idle();

        // Data-error mode: the model error alone gives a zero denominator.
        set_config(1'b1, 32'd0);
        send_bin(32'h0001_0000, 32'd0, 31'h7FFF_FFFF, 31'd0, 1'b1);
        send_bin(32'h0002_0000, 32'd0, 31'h7FFF_FFFF, 31'h0001_0000, 1'b1);
        release_input();
        wait_idle();

        // Threshold at its top: just below is skipped, 2^32 passes.
        set_config(1'b0, 32'hFFFF_FFFF);
        send_bin(32'h0001_0000, 32'd0, 31'd0, 31'h0000_FFFF, 1'b0);
        send_bin(32'h0001_0000, 32'd0, 31'd0, 31'h0001_0000, 1'b1);
        release_input();
        wait_idle();

        // Threshold met exactly counts, one step below does not.
        set_config(1'b0, 32'h0001_0000);
        send_bin(32'h0000_0100, 32'd0, 31'h0000_0100, 31'd0, 1'b0);
        send_bin(32'h0000_0100, 32'd0, 31'h0000_00FF, 31'd0, 1'b1);
        release_input();
        wait_idle();

        // Random runs across several settings, extremes included.
        set_config(1'b1, 32'd0);
        random_bins($urandom_range(70, 100));
        set_config(1'b0, 32'hFFFF_FFFF);
        random_bins($urandom_range(70, 100));
        set_config(1'b1, 32'hFFFF_FFFF);
        random_bins($urandom_range(70, 100));
        set_config(1'b0, 32'd0);
        random_bins($urandom_range(70, 100));
        set_config(1'b1, 32'd1);
        random_bins($urandom_range(70, 100));
        set_config(1'b0, $urandom >> $urandom_range(0, 31));
        random_bins($urandom_range(70, 100));
        set_config(1'b1, $urandom >> $urandom_range(0, 31));
        random_bins($urandom_range(70, 100));
        set_config(1'b0, 32'd1);
        random_bins($urandom_range(70, 100));

        if (mismatch_count == 0 && sums_outstanding == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
